/* rtl/core/lsra_pkg.sv */
// types, constants and the register pool table of the linear scan allocator
// no dependencies; used by lsra_ctrl, lsra_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package lsra_pkg;

  // fixed field widths
  localparam int unsigned VREG_BITS = 16;
  localparam int unsigned POS_BITS  = 16;
  localparam int unsigned PHYS_BITS = 5;

  // one live interval
  typedef struct packed {
    logic                 new_group;
    logic [VREG_BITS-1:0] virt_reg;
    logic [POS_BITS-1:0]  interval_start;
    logic [POS_BITS-1:0]  interval_end;
  } item_t;

  // one allocation result
  typedef struct packed {
    logic [VREG_BITS-1:0] out_virt_reg;
    logic [PHYS_BITS-1:0] phys_reg;
    logic                 spilled;
    logic                 evicted_valid;
    logic [VREG_BITS-1:0] evicted_virt_reg;
  } result_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch the interval, refill on new group
    logic retire;  // drop the head of the active list and push its register
    logic alloc;   // pop a free register or steal from the latest end
    logic insert;  // sorted insert of the new interval, result complete
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic expire_hit;  // head of the active list ends before the new start
  } stat_t;

  // pool of allocatable registers: temporaries first, then a0 to a7 and s2
  function automatic logic [PHYS_BITS-1:0] pool_reg(input logic [3:0] idx);
    logic [PHYS_BITS-1:0] r;
    case (idx)
      4'd0:    r = 5'd5;
      4'd1:    r = 5'd6;
      4'd2:    r = 5'd7;
      4'd3:    r = 5'd28;
      4'd4:    r = 5'd29;
      4'd5:    r = 5'd30;
      4'd6:    r = 5'd31;
      4'd7:    r = 5'd10;
      4'd8:    r = 5'd11;
      4'd9:    r = 5'd12;
      4'd10:   r = 5'd13;
      4'd11:   r = 5'd14;
      4'd12:   r = 5'd15;
      4'd13:   r = 5'd16;
      4'd14:   r = 5'd17;
      4'd15:   r = 5'd18;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lsra_ctrl.sv */
// sequencing state machine of the linear scan allocator
// depends on lsra_pkg (cmd_t, stat_t)
`timescale 1ns / 1ps
`default_nettype none

module lsra_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start,
  output logic             busy,
  input  wire              cfg_we_i,
  input  wire              cfg_wdata_i,
  input  lsra_pkg::stat_t  stat_i,
  output lsra_pkg::cmd_t   cmd_o,
  output logic             result_valid_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RETIRE,
    S_ALLOC,
    S_INSERT
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;
  logic   spill_all_q, spill_all_d;

  // command decode and next state
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    valid_d     = 1'b0;
    spill_all_d = cfg_we_i ? cfg_wdata_i : spill_all_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = spill_all_q ? S_INSERT : S_RETIRE;
        end
      end
      S_RETIRE: begin
        if (stat_i.expire_hit) begin
          cmd_o.retire = 1'b1;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd_o.alloc = 1'b1;
        state_d     = S_INSERT;
      end
      S_INSERT: begin
        cmd_o.insert = 1'b1;
        valid_d      = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state, result strobe and spill-all register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= 1'b0;
      spill_all_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      spill_all_q <= spill_all_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;

endmodule

`default_nettype wire

/* rtl/core/lsra_dp.sv */
// datapath of the linear scan allocator: active list sorted by end, free stack
// depends on lsra_pkg (item_t, result_t, cmd_t, stat_t, pool_reg)
`timescale 1ns / 1ps
`default_nettype none

module lsra_dp #(
  parameter int unsigned NUM_REGS = 7
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  lsra_pkg::cmd_t   cmd_i,
  input  lsra_pkg::item_t  item_i,
  output lsra_pkg::stat_t  stat_o,
  output lsra_pkg::result_t result_o
);

  localparam int unsigned CNT_W = $clog2(NUM_REGS + 1);
  localparam int unsigned IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_REGS);

  // active list, sorted by ascending end
  logic [lsra_pkg::VREG_BITS-1:0] act_vreg_q [NUM_REGS];
  logic [lsra_pkg::POS_BITS-1:0]  act_end_q  [NUM_REGS];
  logic [lsra_pkg::PHYS_BITS-1:0] act_phys_q [NUM_REGS];
  logic [CNT_W-1:0]               act_cnt_q, act_cnt_d;

  // free register stack
  logic [lsra_pkg::PHYS_BITS-1:0] stk_q [NUM_REGS];
  logic [CNT_W-1:0]               stk_cnt_q, stk_cnt_d;

  // latched interval and result
  lsra_pkg::item_t                in_q;
  logic [lsra_pkg::PHYS_BITS-1:0] res_phys_q;
  logic                           res_spill_q;
  logic                           res_ev_q;
  logic [lsra_pkg::VREG_BITS-1:0] res_evv_q;

  logic [CNT_W-1:0]    stk_top, act_last;
  logic                pop_ok, steal_ok, ins_ok;
  logic [NUM_REGS-1:0] keep;

  assign stk_top  = stk_cnt_q - CNT_W'(1);
  assign act_last = act_cnt_q - CNT_W'(1);

  // expiry of the list head
  assign stat_o.expire_hit = (act_cnt_q != '0) && (act_end_q[0] < in_q.interval_start);

  // allocation choice
  assign pop_ok   = (stk_cnt_q != '0);
  assign steal_ok = !pop_ok && (act_cnt_q != '0)
                    && (act_end_q[act_last[IDX_W-1:0]] > in_q.interval_end);
  assign ins_ok   = !res_spill_q && (act_cnt_q < CNT_FULL);

  // entries that stay in place on insert (a prefix, the list being sorted)
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      keep[i] = (CNT_W'(i) < act_cnt_q) && (act_end_q[i] <= in_q.interval_end);
    end
  end

  // counts
  always_comb begin
    act_cnt_d = act_cnt_q;
    stk_cnt_d = stk_cnt_q;
    if (cmd_i.load && item_i.new_group) begin
      act_cnt_d = '0;
      stk_cnt_d = CNT_FULL;
    end else if (cmd_i.retire) begin
      act_cnt_d = act_last;
      if (stk_cnt_q < CNT_FULL) begin
        stk_cnt_d = stk_cnt_q + CNT_W'(1);
      end
    end else if (cmd_i.alloc) begin
      if (pop_ok) begin
        stk_cnt_d = stk_top;
      end else if (steal_ok) begin
        act_cnt_d = act_last;
      end
    end else if (cmd_i.insert && ins_ok) begin
      act_cnt_d = act_cnt_q + CNT_W'(1);
    end
  end

  // counts and free stack, reset to the full pool
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_cnt_q <= '0;
      stk_cnt_q <= CNT_FULL;
      for (int i = 0; i < NUM_REGS; i++) begin
        stk_q[i] <= lsra_pkg::pool_reg(4'(i));
      end
    end else begin
      act_cnt_q <= act_cnt_d;
      stk_cnt_q <= stk_cnt_d;
      if (cmd_i.load && item_i.new_group) begin
        for (int i = 0; i < NUM_REGS; i++) begin
          stk_q[i] <= lsra_pkg::pool_reg(4'(i));
        end
      end else if (cmd_i.retire && (stk_cnt_q < CNT_FULL)) begin
        stk_q[stk_cnt_q[IDX_W-1:0]] <= act_phys_q[0];
      end
    end
  end

  // interval latch, result and active list contents
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q        <= item_i;
      res_phys_q  <= '0;
      res_spill_q <= 1'b1;
      res_ev_q    <= 1'b0;
      res_evv_q   <= '0;
    end
    if (cmd_i.alloc) begin
      if (pop_ok) begin
        res_phys_q  <= stk_q[stk_top[IDX_W-1:0]];
        res_spill_q <= 1'b0;
      end else if (steal_ok) begin
        res_phys_q  <= act_phys_q[act_last[IDX_W-1:0]];
        res_spill_q <= 1'b0;
        res_ev_q    <= 1'b1;
        res_evv_q   <= act_vreg_q[act_last[IDX_W-1:0]];
      end
    end
    if (cmd_i.retire) begin
      // shift the list down over the retired head
      for (int i = 0; i < NUM_REGS - 1; i++) begin
        act_vreg_q[i] <= act_vreg_q[i+1];
        act_end_q[i]  <= act_end_q[i+1];
        act_phys_q[i] <= act_phys_q[i+1];
      end
    end else if (cmd_i.insert && ins_ok) begin
      // open a slot after the last entry with end not above the new one
      if (!keep[0]) begin
        act_vreg_q[0] <= in_q.virt_reg;
        act_end_q[0]  <= in_q.interval_end;
        act_phys_q[0] <= res_phys_q;
      end
      for (int i = 1; i < NUM_REGS; i++) begin
        if (!keep[i]) begin
          if (keep[i-1]) begin
            act_vreg_q[i] <= in_q.virt_reg;
            act_end_q[i]  <= in_q.interval_end;
            act_phys_q[i] <= res_phys_q;
          end else begin
            act_vreg_q[i] <= act_vreg_q[i-1];
            act_end_q[i]  <= act_end_q[i-1];
            act_phys_q[i] <= act_phys_q[i-1];
          end
        end
      end
    end
  end

  // result fields
  assign result_o.out_virt_reg     = in_q.virt_reg;
  assign result_o.phys_reg         = res_phys_q;
  assign result_o.spilled          = res_spill_q;
  assign result_o.evicted_valid    = res_ev_q;
  assign result_o.evicted_virt_reg = res_evv_q;

endmodule

`default_nettype wire

/* rtl/core/linear_scan_register_allocator.sv */
// top level of the linear scan register allocator: controller plus datapath
// depends on lsra_pkg, lsra_ctrl and lsra_dp
//
//  channel   | handshake                | payload
//  ----------+--------------------------+------------------------------
//  interval  | start, busy (start&!busy)| item_i   (lsra_pkg::item_t)
//  result    | result_valid_o strobe    | result_o (lsra_pkg::result_t)
//  config    | cfg_we_i                 | cfg_wdata_i (spill_all)
//
// an interval keeps busy high through the retire, alloc and insert states, retiring
// expired active intervals (0 to NUM_REGS, one per cycle through the list head);
// in spill-all mode busy is high for one cycle only
// the result strobe comes in the same cycle that busy falls, and the next
// interval may be accepted in that same cycle
// reset empties the active list and fills the free stack with the whole pool
// the receiver cannot stall: each result is shown for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none

module linear_scan_register_allocator #(
  parameter int unsigned NUM_REGS = 7
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  lsra_pkg::item_t   item_i,
  output logic              result_valid_o,
  output lsra_pkg::result_t result_o,
  input  wire               cfg_we_i,
  input  wire               cfg_wdata_i
);

  lsra_pkg::cmd_t  cmd;
  lsra_pkg::stat_t stat;

  // sequencing
  lsra_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .result_valid_o (result_valid_o)
  );

  // active list, free stack and result registers
  lsra_dp #(
    .NUM_REGS (NUM_REGS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .stat_o   (stat),
    .result_o (result_o)
  );

  // an accepted transfer makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted interval did not raise busy");

  // results are single-cycle strobes shown only when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy ##1 !result_valid_o))
    else $error("result strobe overlaps busy or lasts two cycles");

  // a spilled interval carries no register and evicts nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.spilled) |->
      (result_o.phys_reg == '0 && !result_o.evicted_valid))
    else $error("spilled result with register or eviction");

  // an eviction always hands its register to the new interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.evicted_valid) |-> !result_o.spilled)
    else $error("eviction reported for a spilled interval");

endmodule

`default_nettype wire

/* tb/linear_scan_register_allocator_tb.sv */
// self-checking testbench for linear_scan_register_allocator: directed table then random
// interval streams, each result checked against its typed row or the bench's
// behavioural allocator; depends on lsra_pkg and the allocator rtl
`timescale 1ns / 1ps

module linear_scan_register_allocator_tb;

  localparam int NUM_SLOTS     = 7;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 400;
  localparam int TIMEOUT_NS    = 1_000_000;
  localparam int NUM_DIRECTED  = 24;
  localparam int NUM_PHASES    = 6;
  localparam int EXP_DEPTH     = 8;

  // allocation order of the pool, bottom of the free stack first
  localparam logic [lsra_pkg::PHYS_BITS-1:0] POOL_REGS [NUM_SLOTS] = '{
    5'd5, 5'd6, 5'd7, 5'd28, 5'd29, 5'd30, 5'd31
  };

  typedef enum logic {ROW_XFER, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_BOTH} idle_mode_e;

  // one row of the directed table; typed rows carry their result
  typedef struct packed {
    row_kind_e                      kind;
    logic                           cfg_val;
    logic                           new_group;
    logic [lsra_pkg::VREG_BITS-1:0] vreg;
    logic [lsra_pkg::POS_BITS-1:0]  lo_pos;
    logic [lsra_pkg::POS_BITS-1:0]  hi_pos;
    logic                           typed;
    logic [lsra_pkg::PHYS_BITS-1:0] phys;
    logic                           spl;
    logic                           ev;
    logic [lsra_pkg::VREG_BITS-1:0] ev_vreg;
  } dir_row_t;

  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    // fresh pool hands out the stack top first
    '{ROW_XFER, 1'b0, 1'b0, 16'h0001, 16'd0,     16'd10,    1'b1, 5'd31, 1'b0, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b0, 16'h0002, 16'd1,     16'd20,    1'b1, 5'd30, 1'b0, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b0, 16'h0003, 16'd2,     16'd5,     1'b1, 5'd29, 1'b0, 1'b0, 16'h0},
    // expiry returns 29 which is popped again
    '{ROW_XFER, 1'b0, 1'b0, 16'h0004, 16'd6,     16'd30,    1'b1, 5'd29, 1'b0, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b0, 16'h0005, 16'd7,     16'd40,    1'b1, 5'd28, 1'b0, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b0, 16'h0006, 16'd8,     16'd50,    1'b1, 5'd7,  1'b0, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b0, 16'h0007, 16'd9,     16'd60,    1'b1, 5'd6,  1'b0, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b0, 16'h0008, 16'd10,    16'd70,    1'b1, 5'd5,  1'b0, 1'b0, 16'h0},
    // pool empty: steal from the latest end
    '{ROW_XFER, 1'b0, 1'b0, 16'h0009, 16'd10,    16'd15,    1'b1, 5'd5,  1'b0, 1'b1, 16'h0008},
    // pool empty and nothing ends later: spill
    '{ROW_XFER, 1'b0, 1'b0, 16'h000A, 16'd10,    16'hFFFF,  1'b1, 5'd0,  1'b1, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b0, 16'h000B, 16'd10,    16'd60,    1'b1, 5'd0,  1'b1, 1'b0, 16'h0},
    // equal ends keep arrival order, so the newer one is stolen from
    '{ROW_XFER, 1'b0, 1'b0, 16'h000C, 16'd11,    16'd60,    1'b0, 5'd0,  1'b0, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b0, 16'h000D, 16'd11,    16'd59,    1'b0, 5'd0,  1'b0, 1'b0, 16'h0},
    // top positions retire everything, then the start goes backwards
    '{ROW_XFER, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF,  16'hFFFF,  1'b0, 5'd0,  1'b0, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b0, 16'h1234, 16'd0,     16'd0,     1'b0, 5'd0,  1'b0, 1'b0, 16'h0},
    // new group with an end below its start
    '{ROW_XFER, 1'b0, 1'b1, 16'h8000, 16'd100,   16'd3,     1'b1, 5'd31, 1'b0, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b0, 16'h7FFF, 16'd101,   16'd50,    1'b0, 5'd0,  1'b0, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b1, 16'h0000, 16'd0,     16'd0,     1'b1, 5'd31, 1'b0, 1'b0, 16'h0},
    // spill-all mode, new group still honoured
    '{ROW_CFG,  1'b1, 1'b0, 16'h0,    16'd0,     16'd0,     1'b0, 5'd0,  1'b0, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b0, 16'hABCD, 16'd5,     16'd9,     1'b1, 5'd0,  1'b1, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b1, 16'h5555, 16'hFFFF,  16'd0,     1'b1, 5'd0,  1'b1, 1'b0, 16'h0},
    '{ROW_CFG,  1'b0, 1'b0, 16'h0,    16'd0,     16'd0,     1'b0, 5'd0,  1'b0, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b0, 16'h2AAA, 16'd0,     16'd1,     1'b1, 5'd31, 1'b0, 1'b0, 16'h0},
    '{ROW_XFER, 1'b0, 1'b0, 16'hAAAA, 16'd0,     16'hFFFF,  1'b0, 5'd0,  1'b0, 1'b0, 16'h0}
  };

  localparam idle_mode_e PHASE_IDLE [NUM_PHASES] = '{
    IDLE_NONE, IDLE_SENDER, IDLE_BOTH, IDLE_NONE, IDLE_SENDER, IDLE_BOTH
  };
  localparam logic PHASE_SPILL [NUM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam int   PHASE_ITEMS [NUM_PHASES] = '{120, 110, 60, 120, 120, 120};

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  lsra_pkg::item_t   item_d      = '0;
  logic              result_valid_o;
  lsra_pkg::result_t result_d;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_wdata_i = 1'b0;

  // hand-typed expectation travelling with the interval
  logic              typed_valid = 1'b0;
  lsra_pkg::result_t typed_res   = '0;

  // allocator state held by the bench
  logic [lsra_pkg::VREG_BITS-1:0] live_vreg [NUM_SLOTS];
  logic [lsra_pkg::POS_BITS-1:0]  live_end  [NUM_SLOTS];
  logic [lsra_pkg::PHYS_BITS-1:0] live_phys [NUM_SLOTS];
  int                             live_count;
  logic [lsra_pkg::PHYS_BITS-1:0] free_regs [NUM_SLOTS];
  int                             free_count;
  logic                           spill_mode;

  // ring of expected results, oldest at the head
  lsra_pkg::result_t exp_ring [EXP_DEPTH];
  int                exp_head  = 0;
  int                exp_tail  = 0;
  int                exp_level = 0;
  int                err_count = 0;

  linear_scan_register_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_d),
    .result_valid_o(result_valid_o),
    .result_o      (result_d),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // empty the active list and restack the whole pool
  function automatic void refill_pool();
    int i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      free_regs[i] = POOL_REGS[i];
      live_vreg[i] = '0;
      live_end[i]  = '0;
      live_phys[i] = '0;
    end
    live_count = 0;
    free_count = NUM_SLOTS;
  endfunction

  // stable insert ordered by end, equal ends go behind
  function automatic void insert_live(logic [lsra_pkg::VREG_BITS-1:0] vreg,
                                      logic [lsra_pkg::POS_BITS-1:0] hi,
                                      logic [lsra_pkg::PHYS_BITS-1:0] phys);
    int pos;
    int i;
    if (live_count < NUM_SLOTS) begin
      pos = 0;
      while (pos < live_count && live_end[pos] <= hi) pos++;
      for (i = live_count; i > pos; i--) begin
        live_vreg[i] = live_vreg[i-1];
        live_end[i]  = live_end[i-1];
        live_phys[i] = live_phys[i-1];
      end
      live_vreg[pos] = vreg;
      live_end[pos]  = hi;
      live_phys[pos] = phys;
      live_count++;
    end
  endfunction

  // allocation of one interval, updating the bench state
  function automatic lsra_pkg::result_t allocate_interval(lsra_pkg::item_t it);
    lsra_pkg::result_t r;
    int                i;
    int                kept;
    int                last;
    r              = '0;
    r.out_virt_reg = it.virt_reg;
    r.spilled      = 1'b1;
    if (it.new_group) refill_pool();
    if (!spill_mode) begin
      // expire everything ending before the new start, in end order
      kept = 0;
      for (i = 0; i < live_count; i++) begin
        if (live_end[i] < it.interval_start) begin
          if (free_count < NUM_SLOTS) begin
            free_regs[free_count] = live_phys[i];
            free_count++;
          end
        end else begin
          live_vreg[kept] = live_vreg[i];
          live_end[kept]  = live_end[i];
          live_phys[kept] = live_phys[i];
          kept++;
        end
      end
      live_count = kept;
      // pop, else steal from the latest end, else spill
      if (free_count > 0) begin
        free_count--;
        r.phys_reg = free_regs[free_count];
        r.spilled  = 1'b0;
        insert_live(it.virt_reg, it.interval_end, r.phys_reg);
      end else if (live_count > 0) begin
        last = live_count - 1;
        if (live_end[last] > it.interval_end) begin
          r.phys_reg         = live_phys[last];
          r.evicted_valid    = 1'b1;
          r.evicted_virt_reg = live_vreg[last];
          r.spilled          = 1'b0;
          live_count         = last;
          insert_live(it.virt_reg, it.interval_end, r.phys_reg);
        end
      end
    end
    return r;
  endfunction

  // result checking, config tracking and prediction on every accepted transfer
  always @(posedge clk_i) begin
    lsra_pkg::result_t want;
    if (!rst_ni) begin
      spill_mode = 1'b0;
      refill_pool();
    end else begin
      if (result_valid_o) begin
        if (exp_level == 0) begin
          $error("unexpected result for virt_reg %0h", result_d.out_virt_reg);
          err_count++;
        end else begin
          want      = exp_ring[exp_head];
          exp_head  = (exp_head + 1) % EXP_DEPTH;
          exp_level--;
          if (result_d.out_virt_reg !== want.out_virt_reg) begin
            $error("out_virt_reg: expected %0h, got %0h", want.out_virt_reg,
                   result_d.out_virt_reg);
            err_count++;
          end
          if (result_d.phys_reg !== want.phys_reg) begin
            $error("phys_reg: expected %0d, got %0d", want.phys_reg, result_d.phys_reg);
            err_count++;
          end
          if (result_d.spilled !== want.spilled) begin
            $error("spilled: expected %0b, got %0b", want.spilled, result_d.spilled);
            err_count++;
          end
          if (result_d.evicted_valid !== want.evicted_valid) begin
            $error("evicted_valid: expected %0b, got %0b", want.evicted_valid,
                   result_d.evicted_valid);
            err_count++;
          end
          if (result_d.evicted_virt_reg !== want.evicted_virt_reg) begin
            $error("evicted_virt_reg: expected %0h, got %0h", want.evicted_virt_reg,
                   result_d.evicted_virt_reg);
            err_count++;
          end
        end
      end
      if (cfg_we_i) spill_mode = cfg_wdata_i;
      if (start && !busy) begin
        want = allocate_interval(item_d);
        if (exp_level == EXP_DEPTH) begin
          $error("expected result ring overflow");
          err_count++;
        end else begin
          exp_ring[exp_tail] = typed_valid ? typed_res : want;
          exp_tail           = (exp_tail + 1) % EXP_DEPTH;
          exp_level++;
        end
      end
    end
  end

  // hold the interval until the block takes it
  task automatic send_interval(lsra_pkg::item_t it, logic typed, lsra_pkg::result_t res);
    start       <= 1'b1;
    item_d      <= it;
    typed_valid <= typed;
    typed_res   <= res;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic lsra_pkg::item_t noise_interval();
    lsra_pkg::item_t it;
    it.new_group      = 1'($urandom_range(0, 1));
    it.virt_reg       = 16'($urandom_range(0, 65535));
    it.interval_start = 16'($urandom_range(0, 65535));
    it.interval_end   = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  // sender gaps, with junk on the payload while start is low
  task automatic sender_gap(int pct);
    while ($urandom_range(0, 99) < pct) begin
      start  <= 1'b0;
      item_d <= noise_interval();
      @(posedge clk_i);
    end
  endtask

  // wait until every result is back, then let the block settle
  task automatic drain_results();
    int waited;
    waited = 0;
    @(posedge clk_i);
    while (exp_level != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_spill_all(logic val);
    start <= 1'b0;
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly well-formed functions with ascending starts, some junk intervals
  task automatic run_phase(idle_mode_e mode, int n_items);
    lsra_pkg::item_t it;
    int              sent;
    int              left;
    int              pos;
    int              hi;
    int              pct;
    case (mode)
      IDLE_SENDER: pct = 84;
      IDLE_BOTH:   pct = 29;
      default:     pct = 0;
    endcase
    sent = 0;
    left = 0;
    pos  = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        it = noise_interval();
      end else begin
        if (left == 0) begin
          left         = $urandom_range(4, 40);
          pos          = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63000) :
                                                       $urandom_range(0, 64);
          it.new_group = 1'b1;
        end else begin
          pos          = pos + $urandom_range(0, 3);
          it.new_group = 1'b0;
        end
        left--;
        if (pos > 65535) pos = 65535;
        hi = pos + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) :
                                                  $urandom_range(0, 24));
        if (hi > 65535) hi = 65535;
        it.virt_reg       = 16'($urandom_range(0, 65535));
        it.interval_start = 16'(pos);
        it.interval_end   = 16'(hi);
      end
      send_interval(it, 1'b0, '0);
      sent++;
      sender_gap(pct);
      // now and then hold off until the block has answered everything
      if ($urandom_range(0, 79) == 0) begin
        start <= 1'b0;
        drain_results();
      end
    end
  endtask

  // stimulus
  initial begin
    lsra_pkg::item_t   it;
    lsra_pkg::result_t res;
    int                r;
    int                p;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (r = 0; r < NUM_DIRECTED; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        write_spill_all(DIRECTED[r].cfg_val);
      end else begin
        it  = '{DIRECTED[r].new_group, DIRECTED[r].vreg, DIRECTED[r].lo_pos,
                DIRECTED[r].hi_pos};
        res = '{DIRECTED[r].vreg, DIRECTED[r].phys, DIRECTED[r].spl, DIRECTED[r].ev,
                DIRECTED[r].ev_vreg};
        send_interval(it, DIRECTED[r].typed, res);
      end
    end

    // random phases, each under its own idling pattern and mode
    for (p = 0; p < NUM_PHASES; p++) begin
      write_spill_all(PHASE_SPILL[p]);
      run_phase(PHASE_IDLE[p], PHASE_ITEMS[p]);
    end

    start <= 1'b0;
    drain_results();
    if (exp_level != 0) begin
      $error("%0d results never arrived", exp_level);
      err_count++;
    end
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
